### rtl/iss_ctrl_pkg.sv
// Package: word types, command and phase codes, register map and reset values.
`default_nettype none
package iss_ctrl_pkg;

  // event commands
  localparam logic [1:0] CmdTick  = 2'd0;
  localparam logic [1:0] CmdRpm   = 2'd1;
  localparam logic [1:0] CmdAct   = 2'd2;
  localparam logic [1:0] CmdBegin = 2'd3;

  // phase codes
  localparam logic [1:0] PhIgn   = 2'd0;
  localparam logic [1:0] PhCrank = 2'd1;
  localparam logic [1:0] PhRun   = 2'd2;
  localparam logic [1:0] PhShut  = 2'd3;

  // register indexes
  localparam logic [2:0] RegMode     = 3'd0;
  localparam logic [2:0] RegChanEn   = 3'd1;
  localparam logic [2:0] RegRelOff   = 3'd2;
  localparam logic [2:0] RegHoldStop = 3'd3;
  localparam logic [2:0] RegCrankLim = 3'd4;
  localparam logic [2:0] RegIdleTo   = 3'd5;
  localparam logic [2:0] RegRunRpm   = 3'd6;
  localparam logic [2:0] RegPwrHold  = 3'd7;

  // channel enable bit positions
  localparam int EnRunIn   = 0;
  localparam int EnStarter = 1;
  localparam int EnBrake   = 2;
  localparam int EnRunOut  = 3;
  localparam int EnCanRpm  = 4;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  // register reset values
  localparam logic [15:0] RelOffRst   = 16'd1000;
  localparam logic [15:0] HoldStopRst = 16'd2000;
  localparam logic [15:0] CrankLimRst = 16'd5000;
  localparam logic [15:0] RunRpmRst   = 16'd400;
  localparam logic [15:0] PwrHoldRst  = 16'd3000;

  localparam logic [31:0] RpmFreshMs = 32'd500;
  localparam logic [25:0] MsPerS     = 26'd1000;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] now_ms;
    logic        switch_closed;
    logic        run_level;
    logic        brake_level;
    logic [15:0] rpm_value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic        starter_on;
    logic        run_output_on;
    logic        shutdown_requested;
    logic        may_cut_power;
    logic [31:0] shutdown_time;
  } out_word_t;

endpackage
`default_nettype wire

### rtl/ignition_start_stop_controller.sv
// Ignition start/stop controller: timestamped event processing, one word per cycle while the output does not stall.
// Pipeline: two register stages, s1_q and out_q; the result is registered in out_q when the word leaves s1_q.
// Throughput: one word per cycle unless the output stalls; the state update is a single pass of wrapping
// subtract-compares against the state registers.
// Reset: asynchronous active low; clears controller state and valid flags and loads register defaults.
// Events arriving before a begin command act on the reset state.
`default_nettype none
module ignition_start_stop_controller (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire iss_ctrl_pkg::in_word_t           in_word_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output iss_ctrl_pkg::out_word_t               out_word_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [iss_ctrl_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [iss_ctrl_pkg::CfgDataW-1:0] cfg_data_i
);

  // configuration registers
  logic        mode_q;
  logic [4:0]  chan_q;
  logic [15:0] rel_off_q, hold_stop_q, crank_lim_q, idle_to_q, run_rpm_q, pwr_hold_q;

  // pipeline
  logic                    s1_valid_q, out_valid_q;
  iss_ctrl_pkg::in_word_t  s1_q;
  iss_ctrl_pkg::out_word_t out_q, out_d;
  logic                    out_free, advance, accept;

  // controller state
  logic [1:0]  phase_q, phase_d;
  logic        latch_q, latch_d;
  logic        sw_prev_q, sw_prev_d;
  logic        armed_q, armed_d;
  logic        hold_q, hold_d;
  logic [31:0] press_q, press_d;
  logic [31:0] low_q, low_d;
  logic [31:0] crank_q, crank_d;
  logic [31:0] stamp_q, stamp_d;
  logic [31:0] act_q, act_d;
  logic [15:0] rpm_q, rpm_d;
  logic [31:0] rpm_stamp_q, rpm_stamp_d;
  logic        starter_q, starter_d;
  logic        run_out_q, run_out_d;

  // per-word helpers
  logic [31:0] now, now_nz;
  logic        sw, run_lv, brake_lv;
  logic        fresh, running, has_src, run_live;
  logic        rising, falling, do_latch;
  logic [25:0] idle_ms;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign advance     = s1_valid_q && out_free;
  assign in_stall_o  = s1_valid_q && !out_free;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  assign now      = s1_q.now_ms;
  assign now_nz   = (now == 32'd0) ? 32'd1 : now;
  assign sw       = s1_q.switch_closed;
  assign run_lv   = s1_q.run_level;
  assign brake_lv = s1_q.brake_level;

  assign fresh    = chan_q[iss_ctrl_pkg::EnCanRpm] && (rpm_stamp_q != 32'd0) &&
                    ((now - rpm_stamp_q) <= iss_ctrl_pkg::RpmFreshMs);
  assign running  = (chan_q[iss_ctrl_pkg::EnRunIn] && run_lv) ||
                    (fresh && (rpm_q >= run_rpm_q));
  assign has_src  = chan_q[iss_ctrl_pkg::EnRunIn] || chan_q[iss_ctrl_pkg::EnCanRpm];
  assign run_live = chan_q[iss_ctrl_pkg::EnRunIn] || fresh;
  assign rising   = sw && !sw_prev_q;
  assign falling  = !sw && sw_prev_q;
  assign idle_ms  = 26'(idle_to_q) * iss_ctrl_pkg::MsPerS;

  always_comb begin
    phase_d     = phase_q;
    latch_d     = latch_q;
    sw_prev_d   = sw_prev_q;
    armed_d     = armed_q;
    hold_d      = hold_q;
    press_d     = press_q;
    low_d       = low_q;
    crank_d     = crank_q;
    stamp_d     = stamp_q;
    act_d       = act_q;
    rpm_d       = rpm_q;
    rpm_stamp_d = rpm_stamp_q;
    starter_d   = starter_q;
    run_out_d   = run_out_q;
    do_latch    = 1'b0;

    case (s1_q.command)
      iss_ctrl_pkg::CmdTick: begin
        if (latch_q) begin
          sw_prev_d = sw;
        end else begin
          if (mode_q) begin
            if (rising || falling) act_d = now;
            if (rising) begin
              press_d = now;
              hold_d  = 1'b0;
            end
            if (!armed_q) begin
              if (falling) armed_d = 1'b1;
            end else if (sw && !hold_d && ((now - press_d) >= 32'(hold_stop_q))) begin
              hold_d   = 1'b1;
              do_latch = 1'b1;
            end else begin
              if (running) act_d = now;
              if (running && phase_d == iss_ctrl_pkg::PhIgn) phase_d = iss_ctrl_pkg::PhRun;
              case (phase_d)
                iss_ctrl_pkg::PhIgn: begin
                  if (rising) begin
                    if (chan_q[iss_ctrl_pkg::EnBrake] && brake_lv) begin
                      if (chan_q[iss_ctrl_pkg::EnStarter] && !running) begin
                        phase_d   = iss_ctrl_pkg::PhCrank;
                        crank_d   = now;
                        starter_d = 1'b1;
                      end
                    end else begin
                      do_latch = 1'b1;
                    end
                  end
                end
                iss_ctrl_pkg::PhCrank: begin
                  if (running) begin
                    if (chan_q[iss_ctrl_pkg::EnStarter]) starter_d = 1'b0;
                    phase_d = iss_ctrl_pkg::PhRun;
                  end else if (((now - crank_q) >= 32'(crank_lim_q)) ||
                               (falling && !has_src)) begin
                    if (chan_q[iss_ctrl_pkg::EnStarter]) starter_d = 1'b0;
                    phase_d = iss_ctrl_pkg::PhIgn;
                  end
                end
                iss_ctrl_pkg::PhRun: begin
                  if (has_src && !running) phase_d = iss_ctrl_pkg::PhIgn;
                end
                default: ;
              endcase
              // idle timeout only counts while a run source is live
              if (idle_to_q != 16'd0 && run_live && phase_d != iss_ctrl_pkg::PhRun &&
                  ((now - act_d) >= 32'(idle_ms))) begin
                do_latch = 1'b1;
              end
            end
          end else begin
            if (sw) begin
              low_d = 32'd0;
            end else if (low_q == 32'd0) begin
              low_d = now_nz;
            end else if ((now - low_q) >= 32'(rel_off_q)) begin
              do_latch = 1'b1;
            end
          end

          // latch is the last action of the pass, so it overrides output drives
          if (do_latch) begin
            latch_d = 1'b1;
            stamp_d = now_nz;
            if (chan_q[iss_ctrl_pkg::EnStarter]) starter_d = 1'b0;
            if (chan_q[iss_ctrl_pkg::EnRunOut]) run_out_d = 1'b0;
          end else if (chan_q[iss_ctrl_pkg::EnRunOut]) begin
            run_out_d = 1'b1;
          end
          if (!mode_q && has_src) begin
            phase_d = running ? iss_ctrl_pkg::PhRun : iss_ctrl_pkg::PhIgn;
          end
          sw_prev_d = sw;
        end
      end
      iss_ctrl_pkg::CmdRpm: begin
        rpm_d       = s1_q.rpm_value;
        rpm_stamp_d = now_nz;
      end
      iss_ctrl_pkg::CmdAct: begin
        act_d = now;
      end
      iss_ctrl_pkg::CmdBegin: begin
        phase_d     = iss_ctrl_pkg::PhIgn;
        latch_d     = 1'b0;
        hold_d      = 1'b0;
        press_d     = 32'd0;
        low_d       = 32'd0;
        crank_d     = 32'd0;
        stamp_d     = 32'd0;
        act_d       = 32'd0;
        rpm_d       = 16'd0;
        rpm_stamp_d = 32'd0;
        sw_prev_d   = sw;
        armed_d     = !mode_q || !sw;
        if (chan_q[iss_ctrl_pkg::EnRunOut]) run_out_d = 1'b1;
      end
      default: ;
    endcase

    out_d.phase              = latch_d ? iss_ctrl_pkg::PhShut : phase_d;
    out_d.starter_on         = starter_d;
    out_d.run_output_on      = run_out_d;
    out_d.shutdown_requested = latch_d;
    out_d.may_cut_power      = latch_d && ((now - stamp_d) >= 32'(pwr_hold_q)) && !sw_prev_d;
    out_d.shutdown_time      = stamp_d;
  end

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      chan_q      <= 5'd0;
      rel_off_q   <= iss_ctrl_pkg::RelOffRst;
      hold_stop_q <= iss_ctrl_pkg::HoldStopRst;
      crank_lim_q <= iss_ctrl_pkg::CrankLimRst;
      idle_to_q   <= 16'd0;
      run_rpm_q   <= iss_ctrl_pkg::RunRpmRst;
      pwr_hold_q  <= iss_ctrl_pkg::PwrHoldRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        iss_ctrl_pkg::RegMode:     mode_q      <= cfg_data_i[0];
        iss_ctrl_pkg::RegChanEn:   chan_q      <= cfg_data_i[4:0];
        iss_ctrl_pkg::RegRelOff:   rel_off_q   <= cfg_data_i;
        iss_ctrl_pkg::RegHoldStop: hold_stop_q <= cfg_data_i;
        iss_ctrl_pkg::RegCrankLim: crank_lim_q <= cfg_data_i;
        iss_ctrl_pkg::RegIdleTo:   idle_to_q   <= cfg_data_i;
        iss_ctrl_pkg::RegRunRpm:   run_rpm_q   <= cfg_data_i;
        iss_ctrl_pkg::RegPwrHold:  pwr_hold_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) s1_q <= in_word_i;
    if (advance) out_q <= out_d;
  end

  // controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= iss_ctrl_pkg::PhIgn;
      latch_q     <= 1'b0;
      sw_prev_q   <= 1'b0;
      armed_q     <= 1'b0;
      hold_q      <= 1'b0;
      press_q     <= 32'd0;
      low_q       <= 32'd0;
      crank_q     <= 32'd0;
      stamp_q     <= 32'd0;
      act_q       <= 32'd0;
      rpm_q       <= 16'd0;
      rpm_stamp_q <= 32'd0;
      starter_q   <= 1'b0;
      run_out_q   <= 1'b0;
    end else if (advance) begin
      phase_q     <= phase_d;
      latch_q     <= latch_d;
      sw_prev_q   <= sw_prev_d;
      armed_q     <= armed_d;
      hold_q      <= hold_d;
      press_q     <= press_d;
      low_q       <= low_d;
      crank_q     <= crank_d;
      stamp_q     <= stamp_d;
      act_q       <= act_d;
      rpm_q       <= rpm_d;
      rpm_stamp_q <= rpm_stamp_d;
      starter_q   <= starter_d;
      run_out_q   <= run_out_d;
    end
  end

endmodule
`default_nettype wire
